### rtl/rsc_pkg.sv
// Shared types, constants and helpers of the radix string converter.
package rsc_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 31;

    // Fixed field widths.
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int BASE_W    = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int SYMS_W    = 2 * CFG_W;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Special characters.
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'd48;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_LO   = 3'd0,
        REG_SRC_HI   = 3'd1,
        REG_SRC_BASE = 3'd2,
        REG_TGT_LO   = 3'd3,
        REG_TGT_HI   = 3'd4,
        REG_TGT_BASE = 3'd5
    } t_reg_idx;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Class of one input character after lookup.
    typedef enum logic [1:0] {
        K_DIGIT = 2'd0,
        K_MINUS = 2'd1,
        K_BAD   = 2'd2
    } t_kind;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_class_item;

    // Clamp a base register into the range lo..hi.
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b,
                                                     input logic [BASE_W-1:0] lo,
                                                     input logic [BASE_W-1:0] hi);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < lo) begin
            r = lo;
        end else if (b > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

### rtl/rsc_front.sv
// Front end: accepts characters and classifies them against the source alphabet.
module rsc_front #(
    parameter int MAX_SYMBOLS = rsc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rsc_pkg::CHAR_W-1:0]        i_in_char,
    input  logic                              i_in_final,
    input  logic [rsc_pkg::SYMS_W-1:0]        i_src_symbols,
    input  logic [rsc_pkg::BASE_W-1:0]        i_src_base,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output rsc_pkg::t_class_item              o_item
);

    logic                          r_first_seen;
    logic                          n_first_seen;
    logic                          w_found;
    logic [rsc_pkg::DIGIT_W-1:0]   w_digit;

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

    // Lowest matching symbol among the active part of the alphabet.
    always_comb begin
        w_found = 1'b0;
        w_digit = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
            if ((rsc_pkg::BASE_W'(k) < i_src_base) &&
                (i_src_symbols[k*rsc_pkg::CHAR_W +: rsc_pkg::CHAR_W] == i_in_char)) begin
                w_found = 1'b1;
                w_digit = rsc_pkg::DIGIT_W'(k);
            end
        end
    end

    // A minus is a sign only as the first character of a run.
    always_comb begin
        o_item.last  = i_in_final;
        o_item.digit = w_digit;
        if (!r_first_seen && (i_in_char == rsc_pkg::MINUS_CHAR)) begin
            o_item.kind = rsc_pkg::K_MINUS;
        end else if (w_found) begin
            o_item.kind = rsc_pkg::K_DIGIT;
        end else begin
            o_item.kind = rsc_pkg::K_BAD;
        end
    end

    // Track the start of a run: cleared after the final character.
    always_comb begin
        n_first_seen = r_first_seen;
        if (o_q_push) begin
            n_first_seen = !i_in_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seen <= 1'b0;
        end else begin
            r_first_seen <= n_first_seen;
        end
    end

endmodule

### rtl/rsc_queue.sv
// Short first-in first-out queue of classified items between front and back.
module rsc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rsc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/rsc_back.sv
// Back end: accumulates digits, converts to the target base and emits characters.
module rsc_back #(
    parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  rsc_pkg::t_class_item             i_item,
    output logic                             o_q_pop,
    input  logic [rsc_pkg::BASE_W-1:0]       i_src_base,
    input  logic [rsc_pkg::BASE_W-1:0]       i_tgt_base,
    input  logic [rsc_pkg::SYMS_W-1:0]       i_tgt_symbols,
    output logic                             empty,
    input  logic                             pop,
    output logic [rsc_pkg::CHAR_W-1:0]       o_out_char,
    output logic                             o_out_final,
    output logic [rsc_pkg::STATUS_W-1:0]     o_status
);

    localparam int IX_W   = $clog2(VALUE_BITS);
    localparam int PROD_W = VALUE_BITS + rsc_pkg::BASE_W + 1;
    localparam int TRY_W  = rsc_pkg::DIGIT_W + 1;

    typedef enum logic [4:0] {
        S_ACC  = 5'b00001,
        S_ONE  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // Control state.
    t_state                         r_state, n_state;
    logic [VALUE_BITS-1:0]          r_acc, n_acc;
    logic                           r_neg, n_neg;
    logic [rsc_pkg::STATUS_W-1:0]   r_err, n_err;
    logic                           r_out_valid, n_out_valid;

    // Payload and loop registers.
    logic [rsc_pkg::CHAR_W-1:0]     r_out_char, n_out_char;
    logic                           r_out_final, n_out_final;
    logic [rsc_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [rsc_pkg::DIGIT_W-1:0]    r_rem, n_rem;
    logic [IX_W-1:0]                r_bit, n_bit;
    logic [IX_W-1:0]                r_n, n_n;
    logic [IX_W-1:0]                r_idx, n_idx;
    logic [rsc_pkg::DIGIT_W-1:0]    r_buf [VALUE_BITS];
    logic                           w_buf_we;

    logic [PROD_W-1:0]              w_prod;
    logic                           w_ovf;
    logic [TRY_W-1:0]               w_try;
    logic                           w_ge;
    logic [rsc_pkg::DIGIT_W-1:0]    w_new_rem;
    logic [VALUE_BITS-1:0]          w_new_quo;
    logic                           w_out_free;
    logic [rsc_pkg::DIGIT_W-1:0]    w_emit_digit;

    assign empty       = !r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_final = r_out_final;
    assign o_status    = r_out_status;
    assign w_out_free  = !r_out_valid || pop;

    // Multiply-accumulate of one source digit with overflow detection.
    assign w_prod = PROD_W'(r_acc) * PROD_W'(i_src_base) + PROD_W'(i_item.digit);
    assign w_ovf  = |w_prod[PROD_W-1:VALUE_BITS];

    // One restoring division step: bring down the next dividend bit.
    assign w_try     = {r_rem, r_acc[VALUE_BITS-1]};
    assign w_ge      = rsc_pkg::BASE_W'(w_try) >= i_tgt_base;
    assign w_new_rem = w_ge ? rsc_pkg::DIGIT_W'(rsc_pkg::BASE_W'(w_try) - i_tgt_base)
                            : rsc_pkg::DIGIT_W'(w_try);
    assign w_new_quo = {r_acc[VALUE_BITS-2:0], w_ge};

    assign w_emit_digit = r_buf[r_idx];
    assign o_q_pop      = (r_state == S_ACC) && !i_q_empty;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !pop;
        n_out_char   = r_out_char;
        n_out_final  = r_out_final;
        n_out_status = r_out_status;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_n          = r_n;
        n_idx        = r_idx;
        w_buf_we     = 1'b0;
        case (r_state)
            S_ACC: begin
                if (!i_q_empty) begin
                    case (i_item.kind)
                        rsc_pkg::K_MINUS: begin
                            n_neg = 1'b1;
                        end
                        rsc_pkg::K_DIGIT: begin
                            if (r_err == rsc_pkg::ST_OK) begin
                                if (w_ovf) begin
                                    n_err = rsc_pkg::ST_OVERFLOW;
                                end else begin
                                    n_acc = w_prod[VALUE_BITS-1:0];
                                end
                            end
                        end
                        default: begin
                            n_err = rsc_pkg::ST_BAD_DIGIT;
                        end
                    endcase
                    // The last character starts the result phase.
                    if (i_item.last) begin
                        if ((n_err != rsc_pkg::ST_OK) || (n_acc == '0)) begin
                            n_state = S_ONE;
                        end else begin
                            n_state = S_DIV;
                            n_rem   = '0;
                            n_bit   = '0;
                            n_n     = '0;
                        end
                    end
                end
            end
            S_ONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = (r_err == rsc_pkg::ST_OK) ? rsc_pkg::ZERO_CHAR : '0;
                    n_out_final  = 1'b1;
                    n_out_status = r_err;
                    n_acc        = '0;
                    n_neg        = 1'b0;
                    n_err        = rsc_pkg::ST_OK;
                    n_state      = S_ACC;
                end
            end
            S_DIV: begin
                n_acc = w_new_quo;
                n_rem = w_new_rem;
                n_bit = r_bit + 1'b1;
                if (r_bit == IX_W'(VALUE_BITS - 1)) begin
                    // One target digit is complete.
                    w_buf_we = 1'b1;
                    n_n      = r_n + 1'b1;
                    n_rem    = '0;
                    n_bit    = '0;
                    if ((w_new_quo == '0) || (r_n == IX_W'(VALUE_BITS - 1))) begin
                        n_idx   = r_n;
                        n_acc   = '0;
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = rsc_pkg::MINUS_CHAR;
                    n_out_final  = 1'b0;
                    n_out_status = rsc_pkg::ST_OK;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = i_tgt_symbols[w_emit_digit*rsc_pkg::CHAR_W +: rsc_pkg::CHAR_W];
                    n_out_final  = (r_idx == '0);
                    n_out_status = rsc_pkg::ST_OK;
                    if (r_idx == '0) begin
                        n_neg   = 1'b0;
                        n_err   = rsc_pkg::ST_OK;
                        n_state = S_ACC;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_err       <= rsc_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and loop registers need no reset.
    always_ff @(posedge i_clk) begin
        r_out_char   <= n_out_char;
        r_out_final  <= n_out_final;
        r_out_status <= n_out_status;
        r_rem        <= n_rem;
        r_bit        <= n_bit;
        r_n          <= n_n;
        r_idx        <= n_idx;
        if (w_buf_we) begin
            r_buf[r_n] <= w_new_rem;
        end
    end

endmodule

### rtl/radix_string_converter_unit.sv
// Top level of the radix string converter: configuration registers, front, queue and back.
//
// Characters enter through push/full and may arrive one per cycle while the
// two-entry queue has room; the back end takes one queued character per cycle
// while it accumulates and folds it into the accumulator with a single
// multiply-add. After the last character of a run, the back end converts the
// value by restoring division, one quotient bit per cycle, a pass over all
// VALUE_BITS bits of the value (31 by default) for each target digit, and then
// emits one character per cycle while the consumer pops, with a leading minus
// sign for a negative run; an error result or a zero value gives a single
// character. New characters keep being queued meanwhile until the queue fills.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must do so only while the block is idle, which the block itself does not
// enforce.
module radix_string_converter_unit #(
    parameter int MAX_SYMBOLS = rsc_pkg::MAX_SYMBOLS_DEF,
    parameter int VALUE_BITS  = rsc_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [rsc_pkg::CHAR_W-1:0]       i_in_char,
    input  logic                             i_in_final,
    output logic                             empty,
    input  logic                             pop,
    output logic [rsc_pkg::CHAR_W-1:0]       o_out_char,
    output logic                             o_out_final,
    output logic [rsc_pkg::STATUS_W-1:0]     o_status,
    input  logic                             i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rsc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int ITEM_W = $bits(rsc_pkg::t_class_item);

    logic [rsc_pkg::CFG_W-1:0]  r_src_lo, r_src_hi, r_tgt_lo, r_tgt_hi;
    logic [rsc_pkg::BASE_W-1:0] r_src_base, r_tgt_base;
    logic [rsc_pkg::BASE_W-1:0] w_src_base, w_tgt_base;

    rsc_pkg::t_class_item w_front_item;
    rsc_pkg::t_class_item w_q_item;
    logic [ITEM_W-1:0]    w_q_wdata;
    logic [ITEM_W-1:0]    w_q_rdata;
    logic                 w_q_push;
    logic                 w_q_full;
    logic                 w_q_pop;
    logic                 w_q_empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_lo   <= '0;
            r_src_hi   <= '0;
            r_src_base <= rsc_pkg::BASE_W'(10);
            r_tgt_lo   <= '0;
            r_tgt_hi   <= '0;
            r_tgt_base <= rsc_pkg::BASE_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsc_pkg::REG_SRC_LO:   r_src_lo   <= i_cfg_data;
                rsc_pkg::REG_SRC_HI:   r_src_hi   <= i_cfg_data;
                rsc_pkg::REG_SRC_BASE: r_src_base <= i_cfg_data[rsc_pkg::BASE_W-1:0];
                rsc_pkg::REG_TGT_LO:   r_tgt_lo   <= i_cfg_data;
                rsc_pkg::REG_TGT_HI:   r_tgt_hi   <= i_cfg_data;
                rsc_pkg::REG_TGT_BASE: r_tgt_base <= i_cfg_data[rsc_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Bases held inside their legal ranges.
    assign w_src_base = rsc_pkg::clamp_base(r_src_base, rsc_pkg::BASE_W'(1),
                                            rsc_pkg::BASE_W'(MAX_SYMBOLS));
    assign w_tgt_base = rsc_pkg::clamp_base(r_tgt_base, rsc_pkg::BASE_W'(2),
                                            rsc_pkg::BASE_W'(MAX_SYMBOLS));

    rsc_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_char     (i_in_char),
        .i_in_final    (i_in_final),
        .i_src_symbols ({r_src_hi, r_src_lo}),
        .i_src_base    (w_src_base),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_item        (w_front_item)
    );

    assign w_q_wdata = w_front_item;

    rsc_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (rsc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_rdata)
    );

    assign w_q_item = rsc_pkg::t_class_item'(w_q_rdata);

    rsc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_item        (w_q_item),
        .o_q_pop       (w_q_pop),
        .i_src_base    (w_src_base),
        .i_tgt_base    (w_tgt_base),
        .i_tgt_symbols ({r_tgt_hi, r_tgt_lo}),
        .empty         (empty),
        .pop           (pop),
        .o_out_char    (o_out_char),
        .o_out_final   (o_out_final),
        .o_status      (o_status)
    );

    // An error result carries a zero character and closes its run.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != rsc_pkg::ST_OK)) |-> ((o_out_char == '0) && o_out_final))
        else $error("error result with a character or without the final mark");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_status == rsc_pkg::ST_OK) || (o_status == rsc_pkg::ST_BAD_DIGIT) ||
                    (o_status == rsc_pkg::ST_OVERFLOW)))
        else $error("undefined status code on the result ports");

    // The front never writes into a full queue.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("item pushed into a full queue");

    // No result is pending right after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule

### tb/tb_radix_string_converter_unit.sv
// Self-checking testbench of the radix string converter: directed script, random runs, checking.
module tb_radix_string_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    localparam int VALUE_BITS  = VALUE_BITS_DEF;
    localparam int MAX_SYM     = MAX_SYMBOLS_DEF;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

    // Indexes past the end of the register list; writes to them must do nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Alphabets: "01234567", "89ABCDEF" and "89abcdef", symbol k in byte k.
    localparam logic [CFG_W-1:0] DEC_LO_SYMS   = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] HEX_HI_SYMS   = 64'h4645444342413938;
    localparam logic [CFG_W-1:0] LOWER_HI_SYMS = 64'h6665646362613938;

    localparam int N_PHASES     = 7;
    localparam int PHASE_ITEMS  = 58;
    localparam int LONG_HOLD    = 300;
    // The back end takes a division pass over VALUE_BITS bits per digit; the gap is sized from it.
    localparam int LATENCY_GAP  = 2 * VALUE_BITS + 8;
    localparam int SEND_IDLE [4] = '{0, 83, 0, 28};
    localparam int RECV_STALL[4] = '{0, 0, 83, 28};

    // One output character as the block presents it.
    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic                fin;
        logic [STATUS_W-1:0] st;
    } t_out_char;

    // One line of the directed script: a register write or an input item.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [CHAR_W-1:0]    ch;
        logic                 fin;
        bit                   typed;
        t_out_char            want;
    } t_script_row;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 push       = 1'b0;
    logic                 full;
    logic [CHAR_W-1:0]    in_char    = '0;
    logic                 in_final   = 1'b0;
    logic                 empty;
    logic                 pop        = 1'b0;
    logic [CHAR_W-1:0]    out_char;
    logic                 out_final;
    logic [STATUS_W-1:0]  out_status;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0]  src_lo_r   = '0;
    logic [CFG_W-1:0]  src_hi_r   = '0;
    logic [BASE_W-1:0] src_base_r = 5'd10;
    logic [CFG_W-1:0]  tgt_lo_r   = '0;
    logic [CFG_W-1:0]  tgt_hi_r   = '0;
    logic [BASE_W-1:0] tgt_base_r = 5'd10;

    // Run state of the conversion.
    longint unsigned     acc      = 0;
    bit                  neg      = 1'b0;
    bit                  seen     = 1'b0;
    logic [STATUS_W-1:0] run_err  = ST_OK;

    t_out_char   converted_q[$];
    t_script_row script_q[$];
    int          mismatches     = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          rx_hold        = 0;

    radix_string_converter_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_in_char   (in_char),
        .i_in_final  (in_final),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (out_char),
        .o_out_final (out_final),
        .o_status    (out_status),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic logic [CHAR_W-1:0] symbol_of(input logic [CFG_W-1:0] lo,
                                                    input logic [CFG_W-1:0] hi,
                                                    input int unsigned k);
        return (k < 8) ? lo[(k % 8) * 8 +: 8] : hi[(k % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned clamp_to(input logic [BASE_W-1:0] b,
                                             input int unsigned floor_v);
        if (b < floor_v) begin
            return floor_v;
        end
        if (b > MAX_SYM) begin
            return MAX_SYM;
        end
        return int'(b);
    endfunction

    // Folds one character into the run; on the last one, queues the converted characters unless keep is clear.
    task automatic convert_char(input logic [CHAR_W-1:0] c, input logic f, input bit keep);
        int unsigned     sb;
        int unsigned     tb;
        int unsigned     d;
        int              n;
        bit              found;
        longint unsigned v;
        int unsigned     digs [VALUE_BITS];
        sb = clamp_to(src_base_r, 1);
        if (!seen && c == MINUS_CHAR) begin
            neg = 1'b1;
        end else begin
            // The lowest matching index wins when symbols repeat.
            found = 1'b0;
            d = 0;
            for (int k = 0; k < sb; k++) begin
                if (!found && symbol_of(src_lo_r, src_hi_r, k) == c) begin
                    found = 1'b1;
                    d = k;
                end
            end
            if (!found) begin
                run_err = ST_BAD_DIGIT;
            end else if (run_err == ST_OK) begin
                if (acc > (VALUE_MAX - d) / sb) begin
                    run_err = ST_OVERFLOW;
                end else begin
                    acc = acc * sb + d;
                end
            end
        end
        seen = 1'b1;
        if (f) begin
            if (!keep) begin
                // The caller supplies the expectation itself.
            end else if (run_err != ST_OK) begin
                converted_q.push_back('{8'd0, 1'b1, run_err});
            end else if (acc == 0) begin
                converted_q.push_back('{ZERO_CHAR, 1'b1, ST_OK});
            end else begin
                tb = clamp_to(tgt_base_r, 2);
                v = acc;
                n = 0;
                while (v > 0 && n < VALUE_BITS) begin
                    digs[n] = int'(v % tb);
                    v = v / tb;
                    n++;
                end
                if (neg) begin
                    converted_q.push_back('{MINUS_CHAR, 1'b0, ST_OK});
                end
                for (int i = n - 1; i >= 0; i--) begin
                    converted_q.push_back('{symbol_of(tgt_lo_r, tgt_hi_r, digs[i]),
                                            i == 0, ST_OK});
                end
            end
            acc = 0;
            neg = 1'b0;
            seen = 1'b0;
            run_err = ST_OK;
        end
    endtask

    // Offers one item after a random gap and waits until it is taken.
    task automatic send_item(input logic [CHAR_W-1:0] c, input logic f,
                             input bit typed = 1'b0, input t_out_char want = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        in_char  <= c;
        in_final <= f;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
        convert_char(c, f, !typed);
        if (typed) begin
            converted_q.push_back(want);
        end
        items_sent++;
    endtask

    // Stops offering items until every expected character has been taken.
    task automatic drain(input int extra);
        push <= 1'b0;
        @(posedge clk);
        while (converted_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_SRC_LO:   src_lo_r   = val;
            REG_SRC_HI:   src_hi_r   = val;
            REG_SRC_BASE: src_base_r = val[BASE_W-1:0];
            REG_TGT_LO:   tgt_lo_r   = val;
            REG_TGT_HI:   tgt_hi_r   = val;
            REG_TGT_BASE: tgt_base_r = val[BASE_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [SYMS_W-1:0] distinct_symbols();
        logic [SYMS_W-1:0] s;
        bit                used [256];
        logic [CHAR_W-1:0] b;
        s = '0;
        used = '{default: 1'b0};
        for (int k = 0; k < MAX_SYM; k++) begin
            do begin
                b = 8'($urandom);
            end while (used[b]);
            used[b] = 1'b1;
            s[k * 8 +: 8] = b;
        end
        return s;
    endfunction

    // Symbols drawn from a narrow band around the minus, so repeats are common.
    function automatic logic [SYMS_W-1:0] repeated_symbols();
        logic [SYMS_W-1:0] s;
        for (int k = 0; k < MAX_SYM; k++) begin
            s[k * 8 +: 8] = 8'($urandom_range(8'h33, 8'h2a));
        end
        return s;
    endfunction

    task automatic load_phase(input int ph);
        logic [SYMS_W-1:0] src;
        logic [SYMS_W-1:0] tgt;
        logic [CFG_W-1:0]  sbv;
        logic [CFG_W-1:0]  tbv;
        src = {HEX_HI_SYMS, DEC_LO_SYMS};
        tgt = {LOWER_HI_SYMS, DEC_LO_SYMS};
        sbv = 64'd10;
        tbv = 64'd16;
        case (ph)
            0: ;
            1: begin
                src = distinct_symbols();
                tgt = distinct_symbols();
                sbv = 64'd16;
                tbv = 64'd2;
            end
            2: begin
                // Both bases above the limit; upper data bits must be ignored.
                src = repeated_symbols();
                tgt = distinct_symbols();
                sbv = {$urandom, $urandom};
                sbv[BASE_W-1:0] = 5'd31;
                tbv = 64'd31;
            end
            3: begin
                src = '1;
                tgt = distinct_symbols();
                sbv = 64'd0;
                tbv = 64'd0;
            end
            4: begin
                tgt = {{CFG_W{1'b1}}, {CFG_W{1'b0}}};
                sbv = 64'd16;
            end
            default: begin
                src = distinct_symbols();
                tgt = distinct_symbols();
                sbv = 64'($urandom_range(16, 2));
                tbv = 64'($urandom_range(16, 2));
            end
        endcase
        drain(LATENCY_GAP);
        write_reg(REG_SRC_LO, src[CFG_W-1:0]);
        write_reg(REG_SRC_HI, src[SYMS_W-1:CFG_W]);
        write_reg(REG_SRC_BASE, sbv);
        write_reg(REG_TGT_LO, tgt[CFG_W-1:0]);
        write_reg(REG_TGT_HI, tgt[SYMS_W-1:CFG_W]);
        write_reg(REG_TGT_BASE, tbv);
        if (ph == 3) begin
            write_reg(REG_SPARE_6, '1);
            write_reg(REG_SPARE_7, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    // One random run: mostly well-formed numbers, some noise, some lone minus signs.
    task automatic random_run();
        int unsigned       sb;
        int unsigned       len;
        int unsigned       pick;
        logic [CHAR_W-1:0] c;
        sb = clamp_to(src_base_r, 1);
        pick = $urandom_range(99);
        if (pick < 80) begin
            if ($urandom_range(2) == 0) begin
                send_item(MINUS_CHAR, 1'b0);
            end
            len = ($urandom_range(9) < 7) ? $urandom_range(5, 1) : $urandom_range(12, 6);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(39) == 0) begin
                    c = 8'($urandom);
                end else begin
                    c = symbol_of(src_lo_r, src_hi_r, $urandom_range(sb - 1));
                end
                send_item(c, i == len - 1);
            end
        end else if (pick < 92) begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++) begin
                send_item(8'($urandom), i == len - 1);
            end
        end else if ($urandom_range(1) == 0) begin
            send_item(MINUS_CHAR, 1'b1);
        end else begin
            send_item(MINUS_CHAR, 1'b0);
            send_item(MINUS_CHAR, 1'b1);
        end
    endtask

    task automatic add_chars(input string s, input bit ends_run);
        t_script_row r;
        r = '{default: '0};
        for (int i = 0; i < s.len(); i++) begin
            r.ch  = s[i];
            r.fin = ends_run && (i == s.len() - 1);
            script_q.push_back(r);
        end
    endtask

    task automatic add_typed(input logic [CHAR_W-1:0] c, input t_out_char want);
        t_script_row r;
        r = '{default: '0};
        r.ch    = c;
        r.fin   = 1'b1;
        r.typed = 1'b1;
        r.want  = want;
        script_q.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        t_script_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = val;
        script_q.push_back(r);
    endtask

    // Receiver: checks each taken character, then decides whether to pop next cycle.
    always @(posedge clk) begin : rx_side
        t_out_char want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (converted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %0d final %0b status %0d",
                                              out_char, out_final, out_status));
                end else begin
                    want = converted_q.pop_front();
                    if (out_char !== want.ch) begin
                        report_mismatch($sformatf("char %0d, want %0d", out_char, want.ch));
                    end
                    if (out_final !== want.fin) begin
                        report_mismatch($sformatf("final %0b, want %0b", out_final, want.fin));
                    end
                    if (out_status !== want.st) begin
                        report_mismatch($sformatf("status %0d, want %0d", out_status, want.st));
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Main sequence: reset, directed script, random phases, final verdict.
    initial begin
        t_out_char zero_out;
        t_out_char bad_out;
        t_out_char ovf_out;
        bit        cfg_open;
        bit        paused;
        zero_out = '{ZERO_CHAR, 1'b1, ST_OK};
        bad_out  = '{8'd0, 1'b1, ST_BAD_DIGIT};
        ovf_out  = '{8'd0, 1'b1, ST_OVERFLOW};
        cfg_open = 1'b0;

        // Reset alphabets are all zero bytes, so only byte 0 is a digit.
        add_typed(8'h00, zero_out);
        add_typed(MINUS_CHAR, zero_out);
        add_typed(8'hff, bad_out);
        add_chars("-", 1'b0);
        add_typed(MINUS_CHAR, bad_out);
        add_chars("-", 1'b0);
        add_typed(8'h00, zero_out);
        // Hex in, binary out: the largest negative value gives the longest output.
        add_cfg(REG_SRC_LO, DEC_LO_SYMS);
        add_cfg(REG_SRC_HI, HEX_HI_SYMS);
        add_cfg(REG_SRC_BASE, 64'd16);
        add_cfg(REG_TGT_LO, DEC_LO_SYMS);
        add_cfg(REG_TGT_HI, LOWER_HI_SYMS);
        add_cfg(REG_TGT_BASE, 64'd2);
        add_chars("-7FFFFFFF", 1'b1);
        add_chars("8000000", 1'b0);
        add_typed(ZERO_CHAR, ovf_out);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_q[i]) begin
            if (script_q[i].is_cfg) begin
                if (!cfg_open) begin
                    drain(LATENCY_GAP);
                end
                write_reg(script_q[i].idx, script_q[i].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_item(script_q[i].ch, script_q[i].fin, script_q[i].typed,
                          script_q[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            load_phase(ph);
            send_idle_pct  = SEND_IDLE[ph % 4];
            recv_stall_pct = RECV_STALL[ph % 4];
            // Starve the output while items keep coming, so the input backs up.
            if (ph == 0) begin
                rx_hold = LONG_HOLD;
            end
            items_sent = 0;
            paused = 1'b0;
            while (items_sent < PHASE_ITEMS) begin
                random_run();
                if (ph == 2 && !paused && items_sent >= PHASE_ITEMS / 2) begin
                    drain(0);
                    paused = 1'b1;
                end
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain(LATENCY_GAP);
        if (mismatches == 0) begin
            $display("** radix_string_converter_unit: PASSED **");
        end else begin
            $display("** radix_string_converter_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #50_000_000;
        $display("** radix_string_converter_unit: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/rsc_pkg.sv
rtl/rsc_front.sv
rtl/rsc_queue.sv
rtl/rsc_back.sv
rtl/radix_string_converter_unit.sv
tb/tb_radix_string_converter_unit.sv
